// ===== design/hbef_pkg.sv =====
`timescale 1ns / 1ps
package hbef_pkg;

	localparam int CoordW = 32;
	localparam int MagW   = 33;           // |p1 - p2| stays below 2^32
	localparam int D2W    = 66;           // sum of three squares stays below 3 * 2^64
	localparam int LenW   = 35;           // root bits 34 down to 0
	localparam int KW     = 32;
	localparam int L0W    = 31;
	localparam int QuoW   = 47;           // force magnitude bits below the clamp
	localparam int EnW    = 63;
	localparam int FW     = 48;
	localparam int SqCells  = LenW;
	localparam int DivCells = QuoW;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [EnW-1:0]  ENERGY_MAX = {EnW{1'b1}};
	localparam logic [QuoW-1:0] FMAG_MAX   = {QuoW{1'b1}};

	typedef logic [MagW-1:0] mag_t;

	// payload riding along the square root chain
	typedef struct packed {
		logic            func;
		logic [KW-1:0]   k;
		logic [L0W-1:0]  l0;
		mag_t [2:0]      mag;
		logic [2:0]      dneg;
	} sq_pay_t;

	typedef struct packed {
		logic [D2W-1:0]  rem;
		logic [LenW-1:0] root;
		sq_pay_t         pay;
	} sq_state_t;

	// one restoring divider lane
	typedef struct packed {
		logic [LenW-1:0] rem;
		logic [QuoW-1:0] num;
		logic [QuoW-1:0] quo;
	} dv_lane_t;

	typedef struct packed {
		logic            func;
		logic            zero;
		logic            eneg;
		logic [2:0]      dneg;
		logic [2:0]      ovf;
		logic [EnW-1:0]  energy;
		logic            esat;
		logic [LenW-1:0] len;
	} dv_side_t;

	typedef struct packed {
		dv_lane_t [2:0] lane;
		dv_side_t       side;
	} dv_state_t;

endpackage

// ===== design/hbef_sqrt_cell.sv =====
`timescale 1ns / 1ps
module hbef_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [5:0]          bit_idx,
	input  logic                in_valid,
	input  hbef_pkg::sq_state_t in_st,
	output logic                out_valid,
	output hbef_pkg::sq_state_t out_st
);
	import hbef_pkg::*;

	logic [71:0] trial;
	logic        take;
	sq_state_t   nxt;

	// try root bit: (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
	always_comb begin
		trial = ({37'd0, in_st.root} << (bit_idx + 6'd1)) + (72'd1 << {bit_idx, 1'b0});
		take  = {6'd0, in_st.rem} >= trial;
		nxt   = in_st;
		if (take) begin
			nxt.rem  = in_st.rem - trial[D2W-1:0];
			nxt.root = in_st.root | (LenW'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_st <= nxt;
		end
	end
endmodule

// ===== design/hbef_div_cell.sv =====
`timescale 1ns / 1ps
module hbef_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  hbef_pkg::dv_state_t in_st,
	output logic                out_valid,
	output hbef_pkg::dv_state_t out_st
);
	import hbef_pkg::*;

	dv_state_t       nxt;
	logic [LenW:0]   sh;
	logic            ge;

	// one quotient bit per lane, divisor is the bond length
	always_comb begin
		nxt = in_st;
		sh  = '0;
		ge  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			sh = {in_st.lane[i].rem, in_st.lane[i].num[QuoW-1]};
			ge = sh >= {1'b0, in_st.side.len};
			nxt.lane[i].rem = ge ? LenW'(sh - {1'b0, in_st.side.len}) : sh[LenW-1:0];
			nxt.lane[i].num = {in_st.lane[i].num[QuoW-2:0], 1'b0};
			nxt.lane[i].quo = {in_st.lane[i].quo[QuoW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_st <= nxt;
		end
	end
endmodule

// ===== design/harmonic_bond_energy_force_unit.sv =====
`timescale 1ns / 1ps
// harmonic spring bond unit: each input beat carries two bead positions (signed Q20.12),
// the stiffness k (unsigned Q16.16) and rest length L0 (Q20.12); tuser selects energy (0)
// or force increments (1). one result beat per input beat, in order. the unit is fully
// pipelined and takes a new bond every cycle while the output is not stalled; between input
// acceptance and the output register lie 7 front stages, 35 square root cells, 47 divider
// cells and the output stage. the two cell chains are the bit-serial square root of the
// squared distance and the three-lane restoring divider by the length. a stalled output
// freezes the whole pipe. energy = floor(k*e^2/2^17) in Q39.24, forces k*|e|*|d|/L in
// Q36.12 truncated toward zero, first bead gets the exact negation of the second. status:
// ok, zero distance (force mode, forces zero) or saturated
module harmonic_bond_energy_force_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// first_x, first_y, first_z, second_x, second_y, second_z, stiffness, rest_length, pad
	input  logic [255:0] s_axis_tdata,
	// func
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// energy, first_fx, first_fy, first_fz, second_fx, second_fy, second_fz, pad
	output logic [351:0] m_axis_tdata,
	// status
	output logic [1:0]   m_axis_tuser
);
	import hbef_pkg::*;

	// whole pipe advances unless the output beat is held
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: coordinate differences, split into sign and magnitude
	logic              v_s1;
	logic              func_s1;
	logic [KW-1:0]     k_s1;
	logic [L0W-1:0]    l0_s1;
	mag_t [2:0]        mag_s1;
	logic [2:0]        dneg_s1;
	logic signed [MagW-1:0] dif [3];
	logic [CoordW-1:0] pa [3];
	logic [CoordW-1:0] pb [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pa[i]  = s_axis_tdata[i*CoordW +: CoordW];
			pb[i]  = s_axis_tdata[(i+3)*CoordW +: CoordW];
			dif[i] = $signed({pa[i][CoordW-1], pa[i]}) - $signed({pb[i][CoordW-1], pb[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= s_axis_tuser[0];
			k_s1    <= s_axis_tdata[6*CoordW +: KW];
			l0_s1   <= s_axis_tdata[6*CoordW+KW +: L0W];
			for (int i = 0; i < 3; i++) begin
				dneg_s1[i] <= dif[i][MagW-1];
				mag_s1[i]  <= dif[i][MagW-1] ? MagW'(-dif[i]) : MagW'(dif[i]);
			end
		end
	end

	// stage 2: squares
	logic              v_s2;
	logic [2*MagW-1:0] sq_s2 [3];
	sq_pay_t           pay_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= mag_s1[i] * mag_s1[i];
			end
			pay_s2 <= '{func: func_s1, k: k_s1, l0: l0_s1, mag: mag_s1, dneg: dneg_s1};
		end
	end

	// stage 3: squared distance, head of the square root chain
	sq_state_t sq_st [SqCells+1];
	logic      sq_v  [SqCells+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_st[0].rem  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			sq_st[0].root <= '0;
			sq_st[0].pay  <= pay_s2;
		end
	end

	for (genvar g = 0; g < SqCells; g++) begin : g_sq
		hbef_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.bit_idx  (6'(SqCells - 1 - g)),
			.in_valid (sq_v[g]),
			.in_st    (sq_st[g]),
			.out_valid(sq_v[g+1]),
			.out_st   (sq_st[g+1])
		);
	end

	// stage 4: stretch e = L - L0 as sign and magnitude
	logic            v_s4;
	logic [LenW-1:0] len_s4;
	logic [LenW-1:0] emag_s4;
	logic            eneg_s4;
	sq_pay_t         pay_s4;
	logic [LenW-1:0] len_w;
	logic [LenW-1:0] l0_w;

	assign len_w = sq_st[SqCells].root;
	assign l0_w  = {{(LenW-L0W){1'b0}}, sq_st[SqCells].pay.l0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v[SqCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s4  <= len_w;
			eneg_s4 <= len_w < l0_w;
			emag_s4 <= (len_w < l0_w) ? l0_w - len_w : len_w - l0_w;
			pay_s4  <= sq_st[SqCells].pay;
		end
	end

	// stage 5: e^2 and k*|e|
	logic              v_s5;
	logic [2*LenW-1:0] e2_s5;
	logic [KW+LenW-1:0] ke_s5;
	logic [LenW-1:0]   len_s5;
	logic              eneg_s5;
	sq_pay_t           pay_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s5   <= emag_s4 * emag_s4;
			ke_s5   <= pay_s4.k * emag_s4;
			len_s5  <= len_s4;
			eneg_s5 <= eneg_s4;
			pay_s5  <= pay_s4;
		end
	end

	// stage 6: partial products, e^2 cut into 35-bit halves and k*|e| into 34-bit and 33-bit parts
	logic          v_s6;
	logic [66:0]   eplo_s6;
	logic [66:0]   ephi_s6;
	logic [66:0]   nplo_s6 [3];
	logic [65:0]   nphi_s6 [3];
	logic [LenW-1:0] len_s6;
	logic          eneg_s6;
	logic          func_s6;
	logic [2:0]    dneg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			eplo_s6 <= e2_s5[LenW-1:0] * pay_s5.k;
			ephi_s6 <= e2_s5[2*LenW-1:LenW] * pay_s5.k;
			for (int i = 0; i < 3; i++) begin
				nplo_s6[i] <= ke_s5[33:0] * pay_s5.mag[i];
				nphi_s6[i] <= ke_s5[66:34] * pay_s5.mag[i];
			end
			len_s6  <= len_s5;
			eneg_s6 <= eneg_s5;
			func_s6 <= pay_s5.func;
			dneg_s6 <= pay_s5.dneg;
		end
	end

	// stage 7: recombine, energy, divider setup and clamp check
	logic [101:0] ep;
	logic [99:0]  np [3];
	logic [83:0]  ns [3];
	logic [36:0]  ntop [3];
	dv_state_t    dv_in;
	dv_state_t    dv_st [DivCells+1];
	logic         dv_v  [DivCells+1];

	always_comb begin
		ep             = {35'd0, eplo_s6} + {ephi_s6, 35'd0};
		dv_in.side.func   = func_s6;
		dv_in.side.zero   = len_s6 == '0;
		dv_in.side.eneg   = eneg_s6;
		dv_in.side.dneg   = dneg_s6;
		dv_in.side.len    = len_s6;
		dv_in.side.esat   = ep[101:80] != '0;
		dv_in.side.energy = ep[79:17];
		for (int i = 0; i < 3; i++) begin
			// floor(n / (L * 2^16)) = floor(floor(n / 2^16) / L)
			np[i]   = {33'd0, nplo_s6[i]} + {nphi_s6[i], 34'd0};
			ns[i]   = np[i][99:16];
			ntop[i] = ns[i][83:47];
			dv_in.side.ovf[i]  = ntop[i] >= {2'd0, len_s6};
			dv_in.lane[i].rem  = dv_in.side.ovf[i] ? '0 : ntop[i][LenW-1:0];
			dv_in.lane[i].num  = ns[i][QuoW-1:0];
			dv_in.lane[i].quo  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_st[0] <= dv_in;
		end
	end

	for (genvar g = 0; g < DivCells; g++) begin : g_dv
		hbef_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv_v[g]),
			.in_st    (dv_st[g]),
			.out_valid(dv_v[g+1]),
			.out_st   (dv_st[g+1])
		);
	end

	// output stage: clamp, signs, mode select
	dv_state_t      fin;
	logic [QuoW-1:0] fm [3];
	logic [FW-1:0]   sv [3];
	logic [351:0]    data_d;
	logic [1:0]      stat_d;

	assign fin = dv_st[DivCells];

	always_comb begin
		data_d = '0;
		stat_d = ST_OK;
		for (int i = 0; i < 3; i++) begin
			fm[i] = fin.side.ovf[i] ? FMAG_MAX : fin.lane[i].quo;
			sv[i] = (fin.side.eneg != fin.side.dneg[i]) ? FW'(-{1'b0, fm[i]}) : {1'b0, fm[i]};
		end
		if (!fin.side.func) begin
			data_d[EnW-1:0] = fin.side.esat ? ENERGY_MAX : fin.side.energy;
			stat_d          = fin.side.esat ? ST_SAT : ST_OK;
		end else if (fin.side.zero) begin
			stat_d = ST_ZERO;
		end else begin
			for (int i = 0; i < 3; i++) begin
				data_d[EnW + i*FW +: FW]     = FW'(-sv[i]);
				data_d[EnW + (i+3)*FW +: FW] = sv[i];
			end
			stat_d = (fin.side.ovf != '0) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= dv_v[DivCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= data_d;
			m_axis_tuser <= stat_d;
		end
	end

	// first bead force is the exact negation of the second
	a_force_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (FW'(m_axis_tdata[110:63] + m_axis_tdata[254:207]) == '0) &&
		(FW'(m_axis_tdata[158:111] + m_axis_tdata[302:255]) == '0) &&
		(FW'(m_axis_tdata[206:159] + m_axis_tdata[350:303]) == '0))
		else $error("force pair not balanced");

	// energy and forces never both present
	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[62:0] != '0) |-> m_axis_tdata[351:63] == '0)
		else $error("energy and force both nonzero");

	// zero distance leaves no force
	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_ZERO) |-> m_axis_tdata == '0)
		else $error("zero distance with nonzero result");

endmodule

// ===== dv/tb_harmonic_bond_energy_force_unit.sv =====
`timescale 1ns / 1ps
module tb_harmonic_bond_energy_force_unit;
	import hbef_pkg::*;

	localparam logic FUNC_ENERGY = 1'b0;
	localparam logic FUNC_FORCE  = 1'b1;
	localparam int   HOLD_LEN    = 400;

	typedef struct {
		logic               func;
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [31:0]        k;
		logic [30:0]        l0;
	} bond_t;

	typedef struct {
		logic [62:0]      energy;
		logic [2:0][47:0] f1;
		logic [2:0][47:0] f2;
		logic [1:0]       status;
	} bond_out_t;

	class bond_scoreboard;
		bond_out_t expected_q[$];
		int        errors;

		function new();
			errors = 0;
		endfunction

		function automatic bond_out_t spring_predict(bond_t b);
			logic signed [2:0][32:0] d;
			logic [2:0][32:0]        m;
			logic [127:0]            d2, p, num, den, q;
			logic [34:0]             len, c, emag;
			logic                    eneg, neg;
			logic [46:0]             fm;
			logic [47:0]             sv;
			bond_out_t               r;
			d[0] = {b.ax[31], b.ax} - {b.bx[31], b.bx};
			d[1] = {b.ay[31], b.ay} - {b.by[31], b.by};
			d[2] = {b.az[31], b.az} - {b.bz[31], b.bz};
			d2 = '0;
			for (int i = 0; i < 3; i++) begin
				m[i] = d[i][32] ? -d[i] : d[i];
				d2 += 128'(m[i]) * 128'(m[i]);
			end
			// bitwise floor square root
			len = '0;
			for (int bit_i = 34; bit_i >= 0; bit_i--) begin
				c = len | (35'd1 << bit_i);
				if (128'(c) * 128'(c) <= d2)
					len = c;
			end
			eneg = len < 35'(b.l0);
			emag = eneg ? 35'(b.l0) - len : len - 35'(b.l0);
			r.energy = '0;
			r.f1 = '0;
			r.f2 = '0;
			r.status = ST_OK;
			if (b.func == FUNC_ENERGY) begin
				p = (128'(emag) * 128'(emag) * 128'(b.k)) >> 17;
				if (p > 128'(ENERGY_MAX)) begin
					r.energy = ENERGY_MAX;
					r.status = ST_SAT;
				end else
					r.energy = p[62:0];
			end else if (len == '0) begin
				r.status = ST_ZERO;
			end else begin
				den = 128'(len) << 16;
				for (int i = 0; i < 3; i++) begin
					num = 128'(b.k) * 128'(emag) * 128'(m[i]);
					q = num / den;
					if (q > 128'(FMAG_MAX)) begin
						fm = FMAG_MAX;
						r.status = ST_SAT;
					end else
						fm = q[46:0];
					neg = eneg != d[i][32];
					sv = neg ? -{1'b0, fm} : {1'b0, fm};
					r.f2[i] = sv;
					r.f1[i] = -sv;
				end
			end
			return r;
		endfunction

		function void note_bond(bond_t b);
			expected_q.push_back(spring_predict(b));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(bond_out_t got);
			bond_out_t w;
			if (expected_q.size() == 0) begin
				report("unexpected beat", 64'(got.status), 64'd0);
				return;
			end
			w = expected_q.pop_front();
			if (got.energy !== w.energy) report("energy", 64'(got.energy), 64'(w.energy));
			for (int i = 0; i < 3; i++) begin
				if (got.f1[i] !== w.f1[i]) report("first force", 64'(got.f1[i]), 64'(w.f1[i]));
				if (got.f2[i] !== w.f2[i]) report("second force", 64'(got.f2[i]), 64'(w.f2[i]));
			end
			if (got.status !== w.status) report("status", 64'(got.status), 64'(w.status));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [351:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	bond_scoreboard sb;
	int idle_pct  = 0;   // sender gap chance per cycle
	int stall_pct = 0;   // receiver stall chance per cycle
	int hold_go   = 0;   // bumped to request a long receiver hold
	int hold_seen = 0;
	int hold_cnt  = 0;

	harmonic_bond_energy_force_unit DUT (.*);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver: random stalls plus the occasional long hold
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_cnt <= HOLD_LEN;
			m_axis_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		bond_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.energy = m_axis_tdata[62:0];
			got.f1[0] = m_axis_tdata[110:63];
			got.f1[1] = m_axis_tdata[158:111];
			got.f1[2] = m_axis_tdata[206:159];
			got.f2[0] = m_axis_tdata[254:207];
			got.f2[1] = m_axis_tdata[302:255];
			got.f2[2] = m_axis_tdata[350:303];
			got.status = m_axis_tuser;
			sb.check_result(got);
		end
	end

	task send_bond(bond_t b);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= b.func;
		s_axis_tdata <= {1'b0, b.l0, b.k, b.bz, b.by, b.bx, b.az, b.ay, b.ax};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_bond(b);
	endtask

	task send_spring(logic func, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
			logic [31:0] k, logic [30:0] l0);
		bond_t b;
		b.func = func;
		b.ax = ax; b.ay = ay; b.az = az;
		b.bx = bx; b.by = by; b.bz = bz;
		b.k = k;
		b.l0 = l0;
		send_bond(b);
	endtask

	// random coordinate with random magnitude so both tiny and huge springs appear
	function automatic logic [31:0] rand_coord();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(31);
	endfunction

	task send_random();
		bond_t b;
		logic signed [31:0] delta;
		b.func = $urandom_range(1);
		b.ax = rand_coord(); b.ay = rand_coord(); b.az = rand_coord();
		case ($urandom_range(9))
			0: begin  // coincident beads
				b.bx = b.ax; b.by = b.ay; b.bz = b.az;
			end
			1, 2, 3, 4: begin  // short bonds
				delta = $signed($urandom_range(65535)) - 32768;
				b.bx = b.ax + delta;
				b.by = b.ay - (delta >>> 1);
				b.bz = b.az + $signed($urandom_range(4095)) - 2048;
			end
			default: begin
				b.bx = rand_coord(); b.by = rand_coord(); b.bz = rand_coord();
			end
		endcase
		b.k = $urandom >> $urandom_range(31);
		b.l0 = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(40000));
		send_bond(b);
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_ENERGY;
		m_axis_tready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, both operations, zero distance, clamps
		for (int f = 0; f < 2; f++) begin
			send_spring(f[0], 0, 0, 0, 0, 0, 0, 32'h0001_0000, 31'd4096);
			send_spring(f[0], 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 31'd0);
			send_spring(f[0], 32'h8000_0000, 32'h7FFF_FFFF, 0,
				32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
			send_spring(f[0], 32'h3000, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h1000);
			send_spring(f[0], 0, -32'sh2000, 0, 0, 0, 0, 32'h0002_8000, 31'h7000);
			send_spring(f[0], 5, -7, 3, -5, 7, -3, 0, 31'd12);
			send_spring(f[0], 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
				32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
			send_spring(f[0], 32'h0100_0000, 0, 0, 32'hFF00_0000, 0, 0, 32'hFFFF_FFFF, 31'd1);
			send_spring(f[0], 1, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
			send_spring(f[0], 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
				32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 32'h5555_AAAA, 31'h2AAA_5555);
		end
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 38; stall_pct = 38; end
			endcase
			// long receiver hold while the sender keeps pushing fills the pipe
			if (ph == 0)
				hold_go = hold_go + 1;
			for (int n = 0; n < 470; n++)
				send_random();
			drain();
		end
		stall_pct = 0;
		repeat (120) @(posedge clk);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
